### src/tcw_pkg.sv
// Shared constants, types and command/status structs for the text console writer.
// Depends on nothing; every other file imports it.
`default_nettype none

package tcw_pkg;

    // Screen geometry
    localparam int COLUMNS = 80;
    localparam int ROWS    = 25;
    localparam int CELLS   = COLUMNS * ROWS;

    // Field widths
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int IDX_W  = 11;

    // Character codes
    localparam logic [CHAR_W-1:0] SPACE_CHAR   = 8'd32;
    localparam logic [CHAR_W-1:0] NEWLINE_CHAR = 8'd10;

    // Item function codes
    localparam logic FUNC_PUT  = 1'b0;
    localparam logic FUNC_READ = 1'b1;

    // Controller states, one-hot
    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_READ  = 3'b010,
        S_CLEAR = 3'b100
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic put;        // accept a put beat: update cursor, write cell (not for newline), load result
        logic rd_issue;   // accept a read beat: start the memory read
        logic load_read;  // load the read result into the output register
        logic sweep_wr;   // write one space during the clearing sweep
    } tcw_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic is_read;    // current input beat is a read
        logic wrap;       // current put runs off the last row
        logic sweep_last; // sweep is at the last cell
    } tcw_status_t;

endpackage

`default_nettype wire

### src/tcw_datapath.sv
// Datapath of the text console writer: character plane memory, cursor,
// clearing sweep counter and output payload registers. Uses tcw_pkg.
`default_nettype none

module tcw_datapath
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              func,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [IDX_W-1:0]  cell_index,
    input  wire tcw_cmd_t          cmd,
    output tcw_status_t            status,
    output logic [COL_W-1:0]       cursor_column,
    output logic [ROW_W-1:0]       cursor_row,
    output logic [CHAR_W-1:0]      read_char,
    output logic                   screen_cleared
);

    logic [CHAR_W-1:0] mem [CELLS];

    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [IDX_W-1:0]  sweep_reg;
    logic [CHAR_W-1:0] rdata_reg;
    logic              rd_range_reg;

    logic [COL_W-1:0]  out_col_reg;
    logic [ROW_W-1:0]  out_row_reg;
    logic [CHAR_W-1:0] out_char_reg;
    logic              out_clr_reg;

    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic [ROW_W:0]    row_adv;
    logic [COL_W-1:0]  col_step;
    logic              step_row;
    logic              wrap;
    logic              is_newline;
    logic              rd_in_range;
    logic [IDX_W-1:0]  cell_addr;
    logic [IDX_W-1:0]  rd_addr;
    logic              mem_we;
    logic [IDX_W-1:0]  mem_waddr;
    logic [CHAR_W-1:0] mem_wdata;

    // Work out the cursor after a put
    always_comb
    begin
        is_newline = (char_code == NEWLINE_CHAR);
        col_inc    = {1'b0, col_reg} + (COL_W+1)'(1);
        row_inc    = {1'b0, row_reg} + (ROW_W+1)'(1);
        if (is_newline || col_inc == (COL_W+1)'(COLUMNS))
        begin
            col_step = '0;
            step_row = 1'b1;
        end
        else
        begin
            col_step = col_inc[COL_W-1:0];
            step_row = 1'b0;
        end
        row_adv = step_row ? row_inc : {1'b0, row_reg};
        wrap    = (row_adv == (ROW_W+1)'(ROWS));
        if (wrap)
        begin
            col_next = '0;
            row_next = '0;
        end
        else
        begin
            col_next = col_step;
            row_next = row_adv[ROW_W-1:0];
        end
    end

    // Cell under the cursor and the read address
    assign cell_addr   = IDX_W'(row_reg) * IDX_W'(COLUMNS) + IDX_W'(col_reg);
    assign rd_in_range = (cell_index < IDX_W'(CELLS));
    assign rd_addr     = rd_in_range ? cell_index : '0;

    // Pick the single write port's source
    always_comb
    begin
        mem_we    = cmd.sweep_wr || (cmd.put && !is_newline);
        mem_waddr = cmd.sweep_wr ? sweep_reg : cell_addr;
        mem_wdata = cmd.sweep_wr ? SPACE_CHAR : char_code;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Register the read data
    always_ff @(posedge clk)
    begin
        if (cmd.rd_issue)
        begin
            rdata_reg    <= mem[rd_addr];
            rd_range_reg <= rd_in_range;
        end
    end

    // Advance the cursor and the sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            sweep_reg <= '0;
        end
        else
        begin
            if (cmd.put)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            if (cmd.sweep_wr)
            begin
                sweep_reg <= status.sweep_last ? '0 : sweep_reg + IDX_W'(1);
            end
        end
    end

    // Load the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.put)
        begin
            out_col_reg  <= col_next;
            out_row_reg  <= row_next;
            out_char_reg <= '0;
            out_clr_reg  <= wrap;
        end
        else if (cmd.load_read)
        begin
            out_col_reg  <= col_reg;
            out_row_reg  <= row_reg;
            out_char_reg <= rd_range_reg ? rdata_reg : '0;
            out_clr_reg  <= 1'b0;
        end
    end

    always_comb
    begin
        status.is_read    = (func == FUNC_READ);
        status.wrap       = wrap;
        status.sweep_last = (sweep_reg == IDX_W'(CELLS - 1));
    end

    assign cursor_column  = out_col_reg;
    assign cursor_row     = out_row_reg;
    assign read_char      = out_char_reg;
    assign screen_cleared = out_clr_reg;

    // Cursor stays on the screen
    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(COLUMNS))
        else $error("cursor column off screen");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg < ROW_W'(ROWS))
        else $error("cursor row off screen");

    // A wrapping put leaves the cursor at home
    a_wrap_home: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.put && wrap |=> col_reg == '0 && row_reg == '0)
        else $error("cursor not at home after screen clear");

endmodule

`default_nettype wire

### src/tcw_ctrl.sv
// Controller of the text console writer: state machine, input stall and
// output valid. Uses tcw_pkg; drives tcw_datapath through tcw_cmd_t.
`default_nettype none

module tcw_ctrl
    import tcw_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    output logic             out_valid,
    input  wire logic        out_stall,
    input  wire tcw_status_t status,
    output tcw_cmd_t         cmd
);

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;
    logic   accept;

    // Output register is free when empty or being taken
    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = !((state_reg == S_IDLE) && out_free);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (status.is_read)
                    begin
                        cmd.rd_issue = 1'b1;
                        state_next   = S_READ;
                    end
                    else
                    begin
                        cmd.put = 1'b1;
                        if (status.wrap)
                        begin
                            state_next = S_CLEAR;
                        end
                    end
                end
            end
            S_READ:
            begin
                if (out_free)
                begin
                    cmd.load_read = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            S_CLEAR:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    // Hold the result until taken
    always_comb
    begin
        if (cmd.put || cmd.load_read)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // No beat taken during the sweep
    a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> in_stall)
        else $error("input accepted during clearing sweep");

    // A read beat waits for its data
    a_read_wait: assert property (@(posedge clk) disable iff (!rst_n)
        accept && status.is_read |=> state_reg == S_READ)
        else $error("read did not enter read state");

    // A stalled result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !(cmd.put || cmd.load_read))
        else $error("result overwritten while stalled");

endmodule

`default_nettype wire

### src/text_console_writer.sv
// Top level of the text console writer: joins tcw_ctrl and tcw_datapath.
// Uses tcw_pkg.
//
// Console writer over an 80x25 text plane with one result beat per input
// beat. A put (func 0) writes the byte at the cursor (newline only moves
// the cursor) and returns the new cursor. A read (func 1) goes through the
// registered read port of the plane memory and the S_READ state; indexes
// past the last cell read as zero. The plane has a single write port, so
// after reset, and after any put that runs off the last row, a clearing
// sweep writes spaces one cell a cycle over all 2000 cells, during which
// input beats are stalled. The result register lets the next beat be
// taken in the same cycle its predecessor's result leaves.
`default_nettype none

module text_console_writer
    import tcw_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic              func,
    input  wire logic [CHAR_W-1:0] char_code,
    input  wire logic [IDX_W-1:0]  cell_index,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [COL_W-1:0]       cursor_column,
    output logic [ROW_W-1:0]       cursor_row,
    output logic [CHAR_W-1:0]      read_char,
    output logic                   screen_cleared
);

    tcw_cmd_t    cmd;
    tcw_status_t status;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .func           (func),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .cmd            (cmd),
        .status         (status),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .read_char      (read_char),
        .screen_cleared (screen_cleared)
    );

endmodule

`default_nettype wire

### tb/tb_text_console_writer.sv
// Self-checking bench for text_console_writer: directed table, then random put/read traffic.
// Depends on tcw_pkg and the text_console_writer RTL; predicts results with its own screen model.
`timescale 1ns / 100ps

module tb_text_console_writer
    import tcw_pkg::*;
();

    localparam int RANDOM_ITEMS  = 2000;
    localparam int CALM_TAIL     = 300;
    localparam int STALL_LIMIT   = 8000;
    localparam int DRAIN_CYCLES  = 20;

    typedef struct packed {
        logic [COL_W-1:0]  col;
        logic [ROW_W-1:0]  row;
        logic [CHAR_W-1:0] rd;
        logic              clr;
    } console_res_t;

    typedef struct packed {
        logic              fn;
        logic [CHAR_W-1:0] code;
        logic [IDX_W-1:0]  idx;
        int                reps;
        logic              typed;
        console_res_t      want;
    } stim_row_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic              func = FUNC_PUT;
    logic [CHAR_W-1:0] char_code = '0;
    logic [IDX_W-1:0]  cell_index = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [COL_W-1:0]  cursor_column;
    logic [ROW_W-1:0]  cursor_row;
    logic [CHAR_W-1:0] read_char;
    logic              screen_cleared;

    // Screen model and expected result beats
    logic [CHAR_W-1:0] screen_chars [CELLS];
    int                cur_col;
    int                cur_row;
    console_res_t      pending_results [$];
    stim_row_t         directed [$];

    int mismatch_count = 0;
    int idle_cycles    = 0;
    int stall_left     = 0;
    bit idle_on        = 1'b0;

    text_console_writer dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .func           (func),
        .char_code      (char_code),
        .cell_index     (cell_index),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .cursor_column  (cursor_column),
        .cursor_row     (cursor_row),
        .read_char      (read_char),
        .screen_cleared (screen_cleared)
    );

    always #6 clk = ~clk;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("[%0t] %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    // Apply one beat to the screen model and return the result it should produce
    function automatic console_res_t console_apply(input logic fn, input logic [CHAR_W-1:0] code,
                                                   input logic [IDX_W-1:0] idx);
        console_res_t r;
        r = '0;
        if (fn == FUNC_READ) begin
            if (idx < CELLS)
                r.rd = screen_chars[idx];
        end
        else begin
            if (code == NEWLINE_CHAR) begin
                cur_row++;
                cur_col = 0;
            end
            else begin
                screen_chars[IDX_W'(cur_row * COLUMNS + cur_col)] = code;
                cur_col++;
            end
            if (cur_col >= COLUMNS) begin
                cur_col = 0;
                cur_row++;
            end
            // Running off the last row blanks the whole screen
            if (cur_row >= ROWS) begin
                foreach (screen_chars[k])
                    screen_chars[k] = SPACE_CHAR;
                cur_col = 0;
                cur_row = 0;
                r.clr = 1'b1;
            end
        end
        r.col = COL_W'(cur_col);
        r.row = ROW_W'(cur_row);
        return r;
    endfunction

    // Drive one input beat, with an optional idle burst first; return once accepted
    task automatic send_beat(input logic fn, input logic [CHAR_W-1:0] code,
                             input logic [IDX_W-1:0] idx);
        int gap;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        func       <= fn;
        char_code  <= code;
        cell_index <= idx;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Hold output stalls in bursts, check result beats, watch for a hang
    always @(posedge clk) begin
        console_res_t want;
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else if (idle_on && $urandom_range(0, 4) == 0) begin
            out_stall  <= 1'b1;
            stall_left = $urandom_range(0, 2);
        end
        else begin
            out_stall <= 1'b0;
        end

        if (rst_n && out_valid && !out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with nothing pending", 32'd0, 32'd0);
            end
            else begin
                want = pending_results.pop_front();
                if (cursor_column !== want.col)
                    report_mismatch("cursor_column", 32'(cursor_column), 32'(want.col));
                if (cursor_row !== want.row)
                    report_mismatch("cursor_row", 32'(cursor_row), 32'(want.row));
                if (read_char !== want.rd)
                    report_mismatch("read_char", 32'(read_char), 32'(want.rd));
                if (screen_cleared !== want.clr)
                    report_mismatch("screen_cleared", 32'(screen_cleared), 32'(want.clr));
            end
        end

        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    initial begin
        console_res_t      got;
        logic              fn;
        logic [CHAR_W-1:0] code;
        logic [IDX_W-1:0]  idx;
        int                run_left;
        bit                long_run;

        foreach (screen_chars[k])
            screen_chars[k] = SPACE_CHAR;
        cur_col  = 0;
        cur_row  = 0;
        run_left = 0;

        // Directed rows: reset contents, range edges, zero byte, last-row newline
        directed.push_back('{FUNC_READ, 8'h00, 11'd0,    1, 1'b1, '{7'd0, 5'd0, SPACE_CHAR, 1'b0}});
        directed.push_back('{FUNC_READ, 8'h00, 11'd1999, 1, 1'b1, '{7'd0, 5'd0, SPACE_CHAR, 1'b0}});
        directed.push_back('{FUNC_READ, 8'hFF, 11'd2000, 1, 1'b1, '{7'd0, 5'd0, 8'd0, 1'b0}});
        directed.push_back('{FUNC_READ, 8'h00, 11'd2047, 1, 1'b1, '{7'd0, 5'd0, 8'd0, 1'b0}});
        directed.push_back('{FUNC_PUT,  8'h00, 11'd2047, 1, 1'b1, '{7'd1, 5'd0, 8'd0, 1'b0}});
        directed.push_back('{FUNC_PUT,  8'hFF, 11'd0,    1, 1'b1, '{7'd2, 5'd0, 8'd0, 1'b0}});
        directed.push_back('{FUNC_READ, 8'h00, 11'd0,    1, 1'b1, '{7'd2, 5'd0, 8'd0, 1'b0}});
        directed.push_back('{FUNC_READ, 8'h00, 11'd1,    1, 1'b1, '{7'd2, 5'd0, 8'hFF, 1'b0}});
        directed.push_back('{FUNC_PUT,  NEWLINE_CHAR, 11'd0, 1, 1'b1, '{7'd0, 5'd1, 8'd0, 1'b0}});
        directed.push_back('{FUNC_PUT,  8'h7F, 11'd0,    1, 1'b0, '0});
        directed.push_back('{FUNC_PUT,  8'h80, 11'd0,    1, 1'b0, '0});
        directed.push_back('{FUNC_READ, 8'h00, 11'd81,   1, 1'b0, '0});
        directed.push_back('{FUNC_PUT,  NEWLINE_CHAR, 11'd0, 23, 1'b0, '0});
        directed.push_back('{FUNC_PUT,  8'h41, 11'd0,    1, 1'b0, '0});
        directed.push_back('{FUNC_READ, 8'h00, 11'd1920, 1, 1'b0, '0});
        directed.push_back('{FUNC_PUT,  NEWLINE_CHAR, 11'd0, 1, 1'b1, '{7'd0, 5'd0, 8'd0, 1'b1}});
        directed.push_back('{FUNC_READ, 8'h00, 11'd0,    1, 1'b1, '{7'd0, 5'd0, SPACE_CHAR, 1'b0}});
        directed.push_back('{FUNC_READ, 8'h00, 11'd1920, 1, 1'b1, '{7'd0, 5'd0, SPACE_CHAR, 1'b0}});
        directed.push_back('{FUNC_PUT,  8'h20, 11'd0,    1, 1'b1, '{7'd1, 5'd0, 8'd0, 1'b0}});

        // Hold reset low, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Walk the directed table
        idle_on = 1'b1;
        foreach (directed[k]) begin
            for (int rep = 0; rep < directed[k].reps; rep++) begin
                send_beat(directed[k].fn, directed[k].code, directed[k].idx);
                got = console_apply(directed[k].fn, directed[k].code, directed[k].idx);
                pending_results.push_back(directed[k].typed ? directed[k].want : got);
            end
        end

        // Random traffic: text runs ended by newline, long runs that wrap, reads mixed in
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            idle_on = (n < RANDOM_ITEMS - CALM_TAIL) && ((n / 150) % 3 != 2);
            if ($urandom_range(0, 3) == 0) begin
                fn   = FUNC_READ;
                code = CHAR_W'($urandom);
                if ($urandom_range(0, 1) == 0)
                    idx = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
                else
                    idx = IDX_W'(cur_row * COLUMNS + $urandom_range(0, COLUMNS - 1));
            end
            else begin
                fn  = FUNC_PUT;
                idx = IDX_W'($urandom);
                if (run_left == 0) begin
                    code     = NEWLINE_CHAR;
                    long_run = (cur_row == ROWS - 1) ? ($urandom_range(0, 1) == 0)
                                                     : ($urandom_range(0, 9) == 0);
                    run_left = long_run ? $urandom_range(70, 100) : $urandom_range(0, 12);
                end
                else begin
                    code = CHAR_W'($urandom);
                    run_left--;
                end
            end
            send_beat(fn, code, idx);
            got = console_apply(fn, code, idx);
            pending_results.push_back(got);
        end
        in_valid <= 1'b0;
        idle_on = 1'b0;

        // Drain outstanding results, then let the block settle
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

### sim.f
src/tcw_pkg.sv
src/tcw_datapath.sv
src/tcw_ctrl.sv
src/text_console_writer.sv
tb/tb_text_console_writer.sv
